// ===== hdl/sap_pkg.sv =====
package sap_pkg;

   // Field widths fixed by the box format.
   localparam int COORD_W  = 16;
   localparam int CLASS_W  = 2;
   localparam int STATUS_W = 2;

   // Defaults for the top-level parameters.
   localparam int DEF_ACTIVE_DEPTH = 16;
   localparam int DEF_ID_BITS      = 10;

   // At most this many results are produced for one box.
   localparam int MAX_RESULTS = 16;

   // Value of the ordering register after reset and after a new frame.
   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

   // Operation code that the front end attaches to each queued transaction.
   typedef enum logic [1:0] {
      OP_BOX   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_ORDER = 2'd2
   } op_type;

   localparam int OP_W = $bits(op_type);

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
   } box_coord_type;

   localparam int BOX_W = $bits(box_coord_type);

endpackage

// ===== hdl/sap_front.sv =====
module sap_front
   import sap_pkg::*;
#(
   parameter int ID_BITS = DEF_ID_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [COORD_W-1:0] req_box_min_x,
   input  logic signed [COORD_W-1:0] req_box_max_x,
   input  logic signed [COORD_W-1:0] req_box_min_y,
   input  logic signed [COORD_W-1:0] req_box_max_y,
   input  logic [ID_BITS-1:0] req_box_id,
   input  logic [CLASS_W-1:0] req_box_class,
   output logic               push_valid,
   input  logic               push_ready,
   output op_type             push_op,
   output box_coord_type      push_box,
   output logic [ID_BITS-1:0] push_id,
   output logic [CLASS_W-1:0] push_class
);

   logic signed [COORD_W-1:0] prev_min_x_ff;
   logic signed [COORD_W-1:0] prev_min_x_in;
   logic                      accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   assign push_box.min_x = req_box_min_x;
   assign push_box.max_x = req_box_max_x;
   assign push_box.min_y = req_box_min_y;
   assign push_box.max_y = req_box_max_y;
   assign push_id        = req_box_id;
   assign push_class     = req_box_class;

   // A box that starts left of its predecessor is flagged and leaves the order untouched.
   always_comb begin
      prev_min_x_in = prev_min_x_ff;
      if (req_kind) begin
         push_op = OP_CLEAR;
         if (accept) begin
            prev_min_x_in = COORD_MIN;
         end
      end else if (req_box_min_x < prev_min_x_ff) begin
         push_op = OP_ORDER;
      end else begin
         push_op = OP_BOX;
         if (accept) begin
            prev_min_x_in = req_box_min_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_min_x_ff <= COORD_MIN;
      end else begin
         prev_min_x_ff <= prev_min_x_in;
      end
   end

endmodule

// ===== hdl/sap_queue.sv =====
module sap_queue
   import sap_pkg::*;
#(
   parameter int WIDTH = OP_W + BOX_W + DEF_ID_BITS + CLASS_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   // Two-entry queue: head is what the back end sees, tail catches one more.
   logic             head_valid_ff;
   logic             head_valid_in;
   logic             tail_valid_ff;
   logic             tail_valid_in;
   logic [WIDTH-1:0] head_ff;
   logic [WIDTH-1:0] head_in;
   logic [WIDTH-1:0] tail_ff;
   logic [WIDTH-1:0] tail_in;
   logic             push;
   logic             pop;

   assign push_ready = ~tail_valid_ff;
   assign pop_valid  = head_valid_ff;
   assign pop_data   = head_ff;
   assign push       = push_valid & ~tail_valid_ff;
   assign pop        = head_valid_ff & pop_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_valid_in = 1'b0;
         end else begin
            head_in       = push_data;
            head_valid_in = push;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            tail_in       = push_data;
            tail_valid_in = 1'b1;
         end else begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== hdl/sap_back.sv =====
module sap_back
   import sap_pkg::*;
#(
   parameter int ACTIVE_DEPTH = DEF_ACTIVE_DEPTH,
   parameter int ID_BITS      = DEF_ID_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   output logic                head_ready,
   input  op_type              head_op,
   input  box_coord_type       head_box,
   input  logic [ID_BITS-1:0]  head_id,
   input  logic [CLASS_W-1:0]  head_class,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_pair_valid,
   output logic [ID_BITS-1:0]  rsp_earlier_id,
   output logic [ID_BITS-1:0]  rsp_later_id,
   output logic [CLASS_W-1:0]  rsp_earlier_class,
   output logic [CLASS_W-1:0]  rsp_later_class,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   localparam int CNT_W  = $clog2(ACTIVE_DEPTH + 1);
   localparam int EMIT_W = $clog2(MAX_RESULTS);

   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_COMPACT = 3'b010,
      S_SCAN    = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Active set, packed in arrival order; holes are closed one per cycle.
   logic signed [COORD_W-1:0] ent_max_x_ff [ACTIVE_DEPTH];
   logic signed [COORD_W-1:0] ent_min_y_ff [ACTIVE_DEPTH];
   logic signed [COORD_W-1:0] ent_max_y_ff [ACTIVE_DEPTH];
   logic [ID_BITS-1:0]        ent_id_ff    [ACTIVE_DEPTH];
   logic [CLASS_W-1:0]        ent_cls_ff   [ACTIVE_DEPTH];

   logic [ACTIVE_DEPTH-1:0] alive_ff;
   logic [ACTIVE_DEPTH-1:0] alive_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [ACTIVE_DEPTH-1:0] match_ff;
   logic [ACTIVE_DEPTH-1:0] match_in;
   logic                    full_ff;
   logic                    full_in;
   logic [EMIT_W-1:0]       emit_cnt_ff;
   logic [EMIT_W-1:0]       emit_cnt_in;
   box_coord_type           cur_box_ff;
   box_coord_type           cur_box_in;
   logic [ID_BITS-1:0]      cur_id_ff;
   logic [ID_BITS-1:0]      cur_id_in;
   logic [CLASS_W-1:0]      cur_cls_ff;
   logic [CLASS_W-1:0]      cur_cls_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_pair_ff;
   logic                rsp_pair_in;
   logic [ID_BITS-1:0]  rsp_eid_ff;
   logic [ID_BITS-1:0]  rsp_eid_in;
   logic [ID_BITS-1:0]  rsp_lid_ff;
   logic [ID_BITS-1:0]  rsp_lid_in;
   logic [CLASS_W-1:0]  rsp_ecls_ff;
   logic [CLASS_W-1:0]  rsp_ecls_in;
   logic [CLASS_W-1:0]  rsp_lcls_ff;
   logic [CLASS_W-1:0]  rsp_lcls_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   logic [ACTIVE_DEPTH-1:0] below_cnt;
   logic [ACTIVE_DEPTH-1:0] keep;
   logic [ACTIVE_DEPTH-1:0] ovl;
   logic [ACTIVE_DEPTH-1:0] evict_alive;
   logic [ACTIVE_DEPTH-1:0] holes_idle;
   logic [ACTIVE_DEPTH-1:0] holes_cur;
   logic [ACTIVE_DEPTH-1:0] low_hole;
   logic [ACTIVE_DEPTH-1:0] ge_hole;
   logic [ACTIVE_DEPTH-1:0] low_match;
   logic [ACTIVE_DEPTH-1:0] rest_match;
   logic [ACTIVE_DEPTH-1:0] append_bit;
   logic [ID_BITS-1:0]      sel_id;
   logic [CLASS_W-1:0]      sel_cls;
   box_coord_type           src_box;
   logic                    out_load;
   logic                    shift_en;
   logic                    append_en;
   logic                    final_pair;
   logic [STATUS_W-1:0]     scan_status;

   assign out_load    = ~rsp_valid_ff | rsp_ready;
   assign src_box     = (state_ff == S_IDLE) ? head_box : cur_box_ff;
   assign evict_alive = alive_ff & keep;
   assign holes_idle  = ~evict_alive & below_cnt;
   assign holes_cur   = ~alive_ff & below_cnt;
   assign low_hole    = holes_cur & (~holes_cur + 1'b1);
   assign ge_hole     = ~(low_hole - 1'b1);
   assign low_match   = match_ff & (~match_ff + 1'b1);
   assign rest_match  = match_ff & ~low_match;
   assign append_bit  = {{(ACTIVE_DEPTH-1){1'b0}}, 1'b1} << count_ff;
   assign final_pair  = (rest_match == '0) || (emit_cnt_ff == EMIT_W'(MAX_RESULTS - 1));
   assign scan_status = full_ff ? STATUS_FULL : STATUS_OK;

   // Per-entry compares against every slot in parallel.
   always_comb begin
      sel_id  = '0;
      sel_cls = '0;
      for (int i = 0; i < ACTIVE_DEPTH; i++) begin
         below_cnt[i] = CNT_W'(i) < count_ff;
         keep[i]      = ent_max_x_ff[i] >= head_box.min_x;
         ovl[i]       = (src_box.max_y > ent_min_y_ff[i]) && (src_box.min_y < ent_max_y_ff[i]);
         sel_id       = sel_id | (ent_id_ff[i] & {ID_BITS{low_match[i]}});
         sel_cls      = sel_cls | (ent_cls_ff[i] & {CLASS_W{low_match[i]}});
      end
   end

   always_comb begin
      state_in      = state_ff;
      alive_in      = alive_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      full_in       = full_ff;
      emit_cnt_in   = emit_cnt_ff;
      cur_box_in    = cur_box_ff;
      cur_id_in     = cur_id_ff;
      cur_cls_in    = cur_cls_ff;
      head_ready    = 1'b0;
      shift_en      = 1'b0;
      append_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_pair_in   = rsp_pair_ff;
      rsp_eid_in    = rsp_eid_ff;
      rsp_lid_in    = rsp_lid_ff;
      rsp_ecls_in   = rsp_ecls_ff;
      rsp_lcls_in   = rsp_lcls_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               case (head_op)
                  OP_CLEAR: begin
                     head_ready = 1'b1;
                     alive_in   = '0;
                     count_in   = '0;
                  end
                  OP_ORDER: begin
                     if (out_load) begin
                        head_ready    = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_pair_in   = 1'b0;
                        rsp_eid_in    = '0;
                        rsp_lid_in    = head_id;
                        rsp_ecls_in   = '0;
                        rsp_lcls_in   = head_class;
                        rsp_status_in = STATUS_ORDER;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  OP_BOX: begin
                     head_ready  = 1'b1;
                     cur_box_in  = head_box;
                     cur_id_in   = head_id;
                     cur_cls_in  = head_class;
                     alive_in    = evict_alive;
                     emit_cnt_in = '0;
                     if (holes_idle == '0) begin
                        match_in = evict_alive & ovl;
                        full_in  = count_ff == CNT_W'(ACTIVE_DEPTH);
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_COMPACT;
                     end
                  end
                  default: begin
                     head_ready = 1'b1;
                  end
               endcase
            end
         end
         S_COMPACT: begin
            if (holes_cur != '0) begin
               shift_en = 1'b1;
               alive_in = (alive_ff & ~ge_hole) | ((alive_ff >> 1) & ge_hole);
               count_in = count_ff - 1'b1;
            end else begin
               match_in = alive_ff & ovl;
               full_in  = count_ff == CNT_W'(ACTIVE_DEPTH);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_lid_in    = cur_id_ff;
               rsp_lcls_in   = cur_cls_ff;
               rsp_status_in = scan_status;
               if (match_ff == '0) begin
                  rsp_pair_in = 1'b0;
                  rsp_eid_in  = '0;
                  rsp_ecls_in = '0;
                  rsp_last_in = 1'b1;
               end else begin
                  rsp_pair_in = 1'b1;
                  rsp_eid_in  = sel_id;
                  rsp_ecls_in = sel_cls;
                  rsp_last_in = final_pair;
                  match_in    = rest_match;
                  emit_cnt_in = emit_cnt_ff + 1'b1;
               end
               if ((match_ff == '0) || final_pair) begin
                  state_in = S_IDLE;
                  if (!full_ff) begin
                     append_en = 1'b1;
                     alive_in  = alive_ff | append_bit;
                     count_in  = count_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry storage: shift down over the lowest hole, or append at the fill level.
   for (genvar g = 0; g < ACTIVE_DEPTH; g++) begin : g_entry
      if (g < ACTIVE_DEPTH - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (shift_en && ge_hole[g]) begin
               ent_max_x_ff[g] <= ent_max_x_ff[g+1];
               ent_min_y_ff[g] <= ent_min_y_ff[g+1];
               ent_max_y_ff[g] <= ent_max_y_ff[g+1];
               ent_id_ff[g]    <= ent_id_ff[g+1];
               ent_cls_ff[g]   <= ent_cls_ff[g+1];
            end else if (append_en && append_bit[g]) begin
               ent_max_x_ff[g] <= cur_box_ff.max_x;
               ent_min_y_ff[g] <= cur_box_ff.min_y;
               ent_max_y_ff[g] <= cur_box_ff.max_y;
               ent_id_ff[g]    <= cur_id_ff;
               ent_cls_ff[g]   <= cur_cls_ff;
            end
         end
      end else begin : g_top
         always_ff @(posedge clock) begin
            if (append_en && append_bit[g]) begin
               ent_max_x_ff[g] <= cur_box_ff.max_x;
               ent_min_y_ff[g] <= cur_box_ff.min_y;
               ent_max_y_ff[g] <= cur_box_ff.max_y;
               ent_id_ff[g]    <= cur_id_ff;
               ent_cls_ff[g]   <= cur_cls_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alive_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alive_ff     <= alive_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff      <= match_in;
      full_ff       <= full_in;
      emit_cnt_ff   <= emit_cnt_in;
      cur_box_ff    <= cur_box_in;
      cur_id_ff     <= cur_id_in;
      cur_cls_ff    <= cur_cls_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_eid_ff    <= rsp_eid_in;
      rsp_lid_ff    <= rsp_lid_in;
      rsp_ecls_ff   <= rsp_ecls_in;
      rsp_lcls_ff   <= rsp_lcls_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pair_valid    = rsp_pair_ff;
   assign rsp_earlier_id    = rsp_eid_ff;
   assign rsp_later_id      = rsp_lid_ff;
   assign rsp_earlier_class = rsp_ecls_ff;
   assign rsp_later_class   = rsp_lcls_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTH
   a_alive_in_fill: assert property (@(posedge clock) disable iff (reset)
      (alive_ff & ~below_cnt) == '0)
      else $error("active entry above the fill level");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ACTIVE_DEPTH))
      else $error("fill level exceeds the active set depth");
   a_scan_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (holes_cur == '0))
      else $error("pair scan started on an active set with holes");
   a_nopair_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pair_ff) |-> rsp_last_ff)
      else $error("result without a pair is not marked last");
`endif

endmodule

// ===== hdl/sweep_and_prune_pairs.sv =====
// A box passes from the queue head through the back end's idle state, a compaction state when
// eviction leaves holes in the active set, and the scan state, which loads its results into the
// output register: one per matching entry up to MAX_RESULTS, or one without a pair, and a stall
// at rsp_ready holds it. Frame markers and out-of-order boxes are finished in the idle state.
// The back end takes the next transaction only back in idle; meanwhile the queue buffers it.
// Reset empties the active set, queue and result register and restores the sweep order.
module sweep_and_prune_pairs
   import sap_pkg::*;
#(
   parameter int ACTIVE_DEPTH = DEF_ACTIVE_DEPTH,
   parameter int ID_BITS      = DEF_ID_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic signed [COORD_W-1:0] req_box_min_x,
   input  logic signed [COORD_W-1:0] req_box_max_x,
   input  logic signed [COORD_W-1:0] req_box_min_y,
   input  logic signed [COORD_W-1:0] req_box_max_y,
   input  logic [ID_BITS-1:0]        req_box_id,
   input  logic [CLASS_W-1:0]        req_box_class,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_pair_valid,
   output logic [ID_BITS-1:0]        rsp_earlier_id,
   output logic [ID_BITS-1:0]        rsp_later_id,
   output logic [CLASS_W-1:0]        rsp_earlier_class,
   output logic [CLASS_W-1:0]        rsp_later_class,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_last
);

   // One queue word carries the operation code, the box's min and max x and y, the id and the class.
   localparam int QW = OP_W + BOX_W + ID_BITS + CLASS_W;

   logic               push_valid;
   logic               push_ready;
   op_type             push_op;
   box_coord_type      push_box;
   logic [ID_BITS-1:0] push_id;
   logic [CLASS_W-1:0] push_class;
   logic [QW-1:0]      push_data;

   logic               pop_valid;
   logic               pop_ready;
   logic [QW-1:0]      pop_data;
   op_type             head_op;
   box_coord_type      head_box;
   logic [ID_BITS-1:0] head_id;
   logic [CLASS_W-1:0] head_class;

   // The front end checks the sweep order as each transaction arrives. It owns the
   // ordering register, so an out-of-order box is recognized before it is queued and
   // never disturbs the active set.
   sap_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_box_min_x (req_box_min_x),
      .req_box_max_x (req_box_max_x),
      .req_box_min_y (req_box_min_y),
      .req_box_max_y (req_box_max_y),
      .req_box_id    (req_box_id),
      .req_box_class (req_box_class),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_op       (push_op),
      .push_box      (push_box),
      .push_id       (push_id),
      .push_class    (push_class)
   );

   assign push_data = {push_op, push_box, push_id, push_class};

   // The two-entry queue lets the front accept up to two transactions while the back end is busy
   // compacting the active set or streaming out pairs.
   sap_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign head_op    = op_type'(pop_data[QW-1 -: OP_W]);
   assign head_box   = box_coord_type'(pop_data[QW-OP_W-1 -: BOX_W]);
   assign head_id    = pop_data[CLASS_W +: ID_BITS];
   assign head_class = pop_data[CLASS_W-1:0];

   // The back end evicts expired boxes with parallel compares, closes the holes one
   // per cycle so the set stays in arrival order, then emits one result per matching
   // entry, up to MAX_RESULTS or one without a pair, then appends the box if not full.
   sap_back #(
      .ACTIVE_DEPTH (ACTIVE_DEPTH),
      .ID_BITS      (ID_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (pop_valid),
      .head_ready        (pop_ready),
      .head_op           (head_op),
      .head_box          (head_box),
      .head_id           (head_id),
      .head_class        (head_class),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pair_valid    (rsp_pair_valid),
      .rsp_earlier_id    (rsp_earlier_id),
      .rsp_later_id      (rsp_later_id),
      .rsp_earlier_class (rsp_earlier_class),
      .rsp_later_class   (rsp_later_class),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule
